// ===== sv/prrts_pkg.sv =====
// Package for the priority round-robin task scheduler: sizes, codes, payload types.
// No dependencies.
package prrts_pkg;
  localparam int SLOTS = 16;
  localparam int SW = $clog2(SLOTS);

  typedef enum logic [2:0] {
    CMD_TICK = 3'd0, CMD_ADMIT = 3'd1, CMD_SETPRIO = 3'd2, CMD_WAKE = 3'd3,
    CMD_BLOCK = 3'd4, CMD_KILL = 3'd5, CMD_EXIT = 3'd6, CMD_NONE = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_READY = 2'd0, ST_RUNNING = 2'd1, ST_BLOCKED = 2'd2, ST_DEAD = 2'd3
  } slot_st_t;

  typedef enum logic [1:0] {
    STS_OK = 2'd0, STS_FAIL = 2'd1, STS_FULL = 2'd2, STS_NONE = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] task_id;
    logic [7:0] priority_req;
    logic       is_user;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] current_task;
    logic       switched;
    logic [3:0] assigned_id;
  } res_item_t;
endpackage

// ===== sv/prrts_if.sv =====
// Valid/ready channel interfaces for commands, results and the config write.
// Depends on prrts_pkg.
interface prrts_cmd_if;
  logic valid;
  logic ready;
  prrts_pkg::cmd_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prrts_res_if;
  logic valid;
  logic ready;
  prrts_pkg::res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prrts_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/prrts_scan.sv =====
// Shared scan unit: one slot per cycle while step is high, tracks the best ready candidate
// and the first ready user slot in scan order.
// Depends on prrts_pkg.
module prrts_scan (
  input  logic                     clk,
  input  logic                     start,
  input  logic                     step,
  input  logic                     first,
  input  logic                     member,
  input  logic                     ready_st,
  input  logic                     user,
  input  logic [7:0]               prio,
  input  logic [prrts_pkg::SW-1:0] idx,
  output logic                     best_ok,
  output logic [prrts_pkg::SW-1:0] best,
  output logic [7:0]               best_prio,
  output logic                     usr_ok,
  output logic [prrts_pkg::SW-1:0] usr
);
  logic cand;

  // the first slot examined is the current one and counts even outside the ring
  assign cand = (first || member) && ready_st;

  always_ff @(posedge clk) begin
    if (start) begin
      best_ok <= 1'b0;
      usr_ok <= 1'b0;
      best <= '0;
      best_prio <= '0;
      usr <= '0;
    end else if (step && cand) begin
      // strict compare keeps the first slot of the highest priority
      if (!best_ok || prio > best_prio) begin
        best_ok <= 1'b1;
        best <= idx;
        best_prio <= prio;
      end
      if (user && !usr_ok) begin
        usr_ok <= 1'b1;
        usr <= idx;
      end
    end
  end
endmodule

// ===== sv/priority_round_robin_task_scheduler_core.sv =====
// Priority round-robin task scheduler, top level.
// A command without a selection goes from S_EXEC straight to S_OUT; one that needs
// a selection makes a pass over the 16 slots, one per cycle, and a second on a tie.
// One command in flight; the next one is taken in the cycle after the result beat,
// so a stalled result holds off the next command.
// Reset (rst, synchronous): slot 0 running, others dead, slice length 10.
module priority_round_robin_task_scheduler_core (
  input logic clk,
  input logic rst,
  prrts_cmd_if.sink   cmd,
  prrts_cfg_if.sink   cfg,
  prrts_res_if.source res
);
  import prrts_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SCAN, S_APPLY, S_OUT} fsm_t;
  typedef enum logic [1:0] {SEL_NEXT, SEL_USER} sel_t;

  fsm_t state;
  sel_t sel;
  slot_st_t   slot_state [SLOTS];
  logic [7:0] slot_priority [SLOTS];
  logic       slot_user [SLOTS];
  logic       slot_in_ring [SLOTS];
  logic [7:0] slot_ticks [SLOTS];
  logic [SW:0]   slots_used;
  logic [SW-1:0] running_slot, prev_slot;
  logic [7:0]    slice_len;
  cmd_item_t     c;
  logic [SW:0]   k;
  logic [SW-1:0] idx;
  logic          best_ok, usr_ok, eq_ok, any_ring;
  logic [SW-1:0] best, usr, eq;
  logic [7:0]    best_prio;
  logic [1:0]    status;
  logic [SW-1:0] assigned;
  logic [SW-1:0] tgt;
  logic          tgt_ok;
  logic          exec_scan;

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign res.valid = (state == S_OUT);
  assign res.data.status = status;
  assign res.data.current_task = 4'(running_slot);
  assign res.data.switched = (running_slot != prev_slot);
  assign res.data.assigned_id = 4'(assigned);
  assign idx = running_slot + k[SW-1:0];

  prrts_scan u_scan (
    .clk(clk), .start(state == S_EXEC), .step(state == S_SCAN && !k[SW]),
    .first(k == '0), .member(slot_in_ring[idx]),
    .ready_st(slot_state[idx] == ST_READY), .user(slot_user[idx]),
    .prio(slot_priority[idx]), .idx(idx),
    .best_ok(best_ok), .best(best), .best_prio(best_prio), .usr_ok(usr_ok), .usr(usr)
  );

  // target of set priority / wake
  always_comb begin
    tgt = c.task_id[SW-1:0];
    tgt_ok = 1'b1;
    if (c.task_id == '0) tgt = running_slot;
    else if (32'(c.task_id) >= SLOTS) tgt_ok = 1'b0;
    else if (slot_state[c.task_id[SW-1:0]] == ST_DEAD) tgt_ok = 1'b0;
  end

  // commands that need a selection scan
  always_comb begin
    unique case (cmd_t'(c.command))
      CMD_TICK: exec_scan = (slot_state[running_slot] == ST_DEAD) ||
                            (slot_ticks[running_slot] <= 8'd1);
      CMD_BLOCK: exec_scan = (slot_state[running_slot] != ST_DEAD);
      CMD_KILL: exec_scan = 1'b1;
      default: exec_scan = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slice_len <= 8'd10;
      slots_used <= (SW+1)'(1);
      running_slot <= '0;
      prev_slot <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_state[i] <= (i == 0) ? ST_RUNNING : ST_DEAD;
        slot_priority[i] <= '0;
        slot_user[i] <= 1'b0;
        slot_in_ring[i] <= (i == 0);
        slot_ticks[i] <= 8'd10;
      end
    end else begin
      if (cfg.valid) slice_len <= cfg.data;
      unique case (state)
        S_IDLE: if (cmd.valid) begin
          c <= cmd.data;
          prev_slot <= running_slot;
          status <= STS_OK;
          assigned <= '0;
          state <= S_EXEC;
        end
        S_EXEC: begin
          k <= '0;
          eq_ok <= 1'b0; any_ring <= 1'b0;
          state <= exec_scan ? S_SCAN : S_OUT;
          unique case (cmd_t'(c.command))
            CMD_TICK: begin
              if (slot_state[running_slot] == ST_DEAD) begin
                sel <= SEL_NEXT;
              end else if (slot_ticks[running_slot] > 8'd1) begin
                slot_ticks[running_slot] <= slot_ticks[running_slot] - 8'd1;
              end else begin
                slot_ticks[running_slot] <= slice_len;
                if (slot_state[running_slot] != ST_BLOCKED)
                  slot_state[running_slot] <= ST_READY;
                sel <= SEL_NEXT;
              end
            end
            CMD_ADMIT: begin
              if (32'(slots_used) >= SLOTS) status <= STS_FULL;
              else begin
                slots_used <= slots_used + 1'b1;
                slot_state[slots_used[SW-1:0]] <= ST_READY;
                slot_ticks[slots_used[SW-1:0]] <= slice_len;
                slot_priority[slots_used[SW-1:0]] <= c.priority_req;
                slot_user[slots_used[SW-1:0]] <= c.is_user;
                slot_in_ring[slots_used[SW-1:0]] <= 1'b1;
                assigned <= slots_used[SW-1:0];
              end
            end
            CMD_SETPRIO: begin
              if (!tgt_ok) status <= STS_FAIL;
              else slot_priority[tgt] <= c.priority_req;
            end
            CMD_WAKE: begin
              if (tgt_ok && slot_state[tgt] == ST_BLOCKED) slot_state[tgt] <= ST_READY;
              else status <= STS_FAIL;
            end
            CMD_BLOCK: begin
              if (slot_state[running_slot] == ST_DEAD) status <= STS_FAIL;
              else begin
                slot_state[running_slot] <= ST_BLOCKED;
                sel <= SEL_USER;
              end
            end
            CMD_KILL: begin
              slot_state[running_slot] <= ST_DEAD;
              slot_in_ring[running_slot] <= 1'b0;
              sel <= SEL_NEXT;
            end
            CMD_EXIT: begin
              slot_state[running_slot] <= ST_DEAD;
              slot_in_ring[running_slot] <= 1'b0;
            end
            default: status <= STS_FAIL;
          endcase
        end
        S_SCAN: begin
          // one slot per cycle; the current slot is always examined
          if (slot_in_ring[idx]) any_ring <= 1'b1;
          k <= k + 1'b1;
          if (32'(k) == SLOTS - 1) state <= S_APPLY;
          // equal-priority search is resolved in a second pass
          if (32'(k) >= SLOTS) begin
            if (32'(k) != SLOTS && slot_in_ring[idx] && slot_state[idx] == ST_READY &&
                slot_priority[idx] == best_prio && !eq_ok) begin
              eq_ok <= 1'b1; eq <= idx;
            end
            if (32'(k) == 2*SLOTS - 1) state <= S_APPLY;
            else state <= S_SCAN;
          end
        end
        S_APPLY: begin
          if (32'(k) == SLOTS && sel == SEL_NEXT && any_ring && best_ok &&
              best_prio == slot_priority[running_slot]) begin
            state <= S_SCAN;  // second pass for round-robin tie
          end else begin
            state <= S_OUT;
            if (sel == SEL_USER) begin
              if (!any_ring || !usr_ok || usr == running_slot) begin
                slot_state[running_slot] <= ST_RUNNING;
                status <= STS_FAIL;
              end else begin
                slot_state[usr] <= ST_RUNNING; running_slot <= usr;
              end
            end else begin : apply_next
              logic ok;
              logic [SW-1:0] n;
              ok = any_ring && best_ok;
              n = eq_ok ? eq : best;
              if (cmd_t'(c.command) == CMD_TICK && slot_state[running_slot] != ST_DEAD) begin
                if (!ok || n == running_slot) begin
                  if (slot_state[running_slot] == ST_READY)
                    slot_state[running_slot] <= ST_RUNNING;
                end else begin
                  slot_state[n] <= ST_RUNNING; running_slot <= n;
                end
              end else if (!ok) status <= STS_NONE;
              else begin
                slot_state[n] <= ST_RUNNING; running_slot <= n;
              end
            end
          end
        end
        S_OUT: if (res.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/prrts_checker.sv =====
// Port-level checker for the scheduler core, bound to the top level.
// Depends on prrts_pkg.
module prrts_checker (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic res_valid,
  input logic res_ready,
  input logic [1:0] res_status,
  input logic [3:0] res_assigned_id
);
  import prrts_pkg::*;
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !cmd_ready) else $error("command taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid) else $error("result dropped");
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status == STS_FULL |-> res_assigned_id == '0)
    else $error("assigned id on full table");
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !res_valid) else $error("result too early");
endmodule

bind priority_round_robin_task_scheduler_core prrts_checker u_chk (
  .clk(clk), .rst(rst), .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
  .res_valid(res.valid), .res_ready(res.ready), .res_status(res.data.status),
  .res_assigned_id(res.data.assigned_id)
);

// ===== sim/tb_priority_round_robin_task_scheduler_core.sv =====
// Testbench for priority_round_robin_task_scheduler_core: directed and random commands,
// scoreboarded against an in-bench scheduler model. Bursty sender, stalling receiver.
// Depends on prrts_pkg, prrts_if and the core RTL.
module tb_priority_round_robin_task_scheduler_core;
  import prrts_pkg::*;

  logic clk = 1'b0;
  logic rst;

  prrts_cmd_if cmd_ch();
  prrts_cfg_if cfg_ch();
  prrts_res_if res_ch();

  priority_round_robin_task_scheduler_core dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .cfg(cfg_ch), .res(res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  localparam int DRAIN_CYCLES = 2 * SLOTS + 10;

  // scheduler model state
  slot_st_t         sched_state [SLOTS];
  logic [7:0]       sched_prio  [SLOTS];
  logic             sched_user  [SLOTS];
  logic [SLOTS-1:0] sched_ring;
  logic [7:0]       sched_ticks [SLOTS];
  int               sched_used;
  int               sched_run;
  logic [7:0]       sched_slice;

  res_item_t expected_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_switches = 0;
  int n_full = 0;
  int n_empty = 0;
  int burst_left = 0;

  function automatic int pick_next_task();
    int best, idx;
    logic [7:0] best_prio;
    best = -1;
    best_prio = 8'd0;
    if (sched_ring == '0) return -1;
    for (int k = 0; k < SLOTS; k++) begin
      idx = (sched_run + k) % SLOTS;
      if (k > 0 && !sched_ring[idx]) continue;
      if (sched_state[idx] == ST_READY && (best < 0 || sched_prio[idx] > best_prio)) begin
        best = idx;
        best_prio = sched_prio[idx];
      end
    end
    if (best < 0) return -1;
    // same level as the current task: rotate to the next one in ring order
    if (best_prio == sched_prio[sched_run]) begin
      for (int k = 1; k < SLOTS; k++) begin
        idx = (sched_run + k) % SLOTS;
        if (sched_ring[idx] && sched_state[idx] == ST_READY && sched_prio[idx] == best_prio)
          return idx;
      end
    end
    return best;
  endfunction

  function automatic int pick_user_task();
    int idx;
    if (sched_ring == '0) return -1;
    for (int k = 0; k < SLOTS; k++) begin
      idx = (sched_run + k) % SLOTS;
      if (k > 0 && !sched_ring[idx]) continue;
      if (sched_state[idx] == ST_READY && sched_user[idx]) return idx;
    end
    return -1;
  endfunction

  function automatic int lookup_task(logic [3:0] id);
    if (id == 0) return sched_run;
    if (id >= SLOTS) return -1;
    if (sched_state[id] == ST_DEAD) return -1;
    return id;
  endfunction

  function automatic res_item_t schedule_cmd(cmd_item_t it);
    res_item_t r;
    int n, cur, prev;
    r = '0;
    r.status = STS_OK;
    cur = sched_run;
    prev = sched_run;
    case (it.command)
      CMD_TICK: begin
        if (sched_state[cur] == ST_DEAD) begin
          n = pick_next_task();
          if (n < 0) r.status = STS_NONE;
          else begin
            sched_state[n] = ST_RUNNING;
            sched_run = n;
          end
        end else if (sched_ticks[cur] > 1) begin
          sched_ticks[cur]--;
        end else begin
          sched_ticks[cur] = sched_slice;
          if (sched_state[cur] != ST_BLOCKED) sched_state[cur] = ST_READY;
          n = pick_next_task();
          if (n < 0 || n == cur) begin
            if (sched_state[cur] == ST_READY) sched_state[cur] = ST_RUNNING;
          end else begin
            sched_state[n] = ST_RUNNING;
            sched_run = n;
          end
        end
      end
      CMD_ADMIT: begin
        if (sched_used >= SLOTS) r.status = STS_FULL;
        else begin
          n = sched_used++;
          sched_state[n] = ST_READY;
          sched_ticks[n] = sched_slice;
          sched_prio[n] = it.priority_req;
          sched_user[n] = it.is_user;
          sched_ring[n] = 1'b1;
          r.assigned_id = 4'(n);
        end
      end
      CMD_SETPRIO: begin
        n = lookup_task(it.task_id);
        if (n < 0) r.status = STS_FAIL;
        else sched_prio[n] = it.priority_req;
      end
      CMD_WAKE: begin
        n = lookup_task(it.task_id);
        if (n >= 0 && sched_state[n] == ST_BLOCKED) sched_state[n] = ST_READY;
        else r.status = STS_FAIL;
      end
      CMD_BLOCK: begin
        if (sched_state[cur] == ST_DEAD) r.status = STS_FAIL;
        else begin
          sched_state[cur] = ST_BLOCKED;
          n = pick_user_task();
          if (n < 0 || n == cur) begin
            sched_state[cur] = ST_RUNNING;
            r.status = STS_FAIL;
          end else begin
            sched_state[n] = ST_RUNNING;
            sched_run = n;
          end
        end
      end
      CMD_KILL: begin
        sched_state[cur] = ST_DEAD;
        sched_ring[cur] = 1'b0;
        n = pick_next_task();
        if (n < 0) r.status = STS_NONE;
        else begin
          sched_state[n] = ST_RUNNING;
          sched_run = n;
        end
      end
      CMD_EXIT: begin
        sched_state[cur] = ST_DEAD;
        sched_ring[cur] = 1'b0;
      end
      default: r.status = STS_FAIL;
    endcase
    r.current_task = 4'(sched_run);
    r.switched = (sched_run != prev);
    return r;
  endfunction

  // sender: bursts of random length with random idle gaps
  task automatic send_cmd(input cmd_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= it;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    expected_results.push_back(schedule_cmd(it));
    n_sent++;
  endtask

  task automatic send_fields(input cmd_t c, input int id, input int prio, input bit user);
    cmd_item_t it;
    it.command = c;
    it.task_id = 4'(id);
    it.priority_req = 8'(prio);
    it.is_user = user;
    send_cmd(it);
  endtask

  // hold off until every result is back, then let the core settle
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_slice(input logic [7:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sched_slice = v;
  endtask

  function automatic cmd_item_t random_cmd(bit allow_deaths);
    cmd_item_t it;
    int r;
    r = $urandom_range(0, 999);
    if (r < 450) it.command = CMD_TICK;
    else if (r < 480) it.command = CMD_ADMIT;
    else if (r < 630) it.command = CMD_SETPRIO;
    else if (r < 800) it.command = CMD_WAKE;
    else if (r < 960) it.command = CMD_BLOCK;
    else if (r < 980) it.command = CMD_NONE;
    else if (allow_deaths && r < 985) it.command = CMD_KILL;
    else if (allow_deaths && r < 990) it.command = CMD_EXIT;
    else it.command = CMD_TICK;
    it.task_id = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
    case ($urandom_range(0, 5))
      0: it.priority_req = 8'd0;
      1: it.priority_req = 8'd255;
      2: it.priority_req = 8'($urandom_range(0, 3));
      default: it.priority_req = 8'($urandom);
    endcase
    it.is_user = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // receiver stalls: one of four random ready patterns, picked anew when the hold counter runs out
  int stall_mode = 0;
  int stall_count = 0;
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_count <= $urandom_range(50, 400);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: res_ch.ready <= 1'b1;
      1: res_ch.ready <= 1'($urandom_range(0, 1));
      2: res_ch.ready <= ($urandom_range(0, 7) != 0);
      default: res_ch.ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    res_item_t exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat %h", $time, res_ch.data);
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        if (exp_r.switched) n_switches++;
        if (exp_r.status == STS_FULL) n_full++;
        if (exp_r.status == STS_NONE) n_empty++;
        if (res_ch.data.status != exp_r.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_r.status, res_ch.data.status);
        end
        if (res_ch.data.current_task != exp_r.current_task) begin
          errors++;
          $display("%0t: current_task expected %0d actual %0d", $time,
                   exp_r.current_task, res_ch.data.current_task);
        end
        if (res_ch.data.switched != exp_r.switched) begin
          errors++;
          $display("%0t: switched expected %0d actual %0d", $time,
                   exp_r.switched, res_ch.data.switched);
        end
        if (res_ch.data.assigned_id != exp_r.assigned_id) begin
          errors++;
          $display("%0t: assigned_id expected %0d actual %0d", $time,
                   exp_r.assigned_id, res_ch.data.assigned_id);
        end
      end
    end
  end

  task automatic test_basics();
    send_fields(CMD_TICK, 0, 0, 0);
    send_fields(CMD_ADMIT, 0, 0, 0);
    send_fields(CMD_ADMIT, 0, 255, 1);
    send_fields(CMD_ADMIT, 0, 255, 0);
    send_fields(CMD_ADMIT, 0, 7, 1);
    send_fields(CMD_SETPRIO, 15, 3, 0);     // dead slot
    send_fields(CMD_SETPRIO, 0, 255, 0);    // current task
    send_fields(CMD_WAKE, 2, 0, 0);         // not blocked
    send_fields(CMD_BLOCK, 0, 0, 0);
    send_fields(CMD_WAKE, 0, 0, 0);         // current is not blocked now
    send_fields(CMD_WAKE, 14, 0, 0);        // dead target
    send_fields(CMD_NONE, 9, 128, 1);
    repeat (4) send_fields(CMD_TICK, 0, 0, 0);
    send_fields(CMD_EXIT, 0, 0, 0);
    send_fields(CMD_SETPRIO, 0, 1, 0);      // id 0 names the dead current task
    send_fields(CMD_BLOCK, 0, 0, 0);        // dead current
    send_fields(CMD_TICK, 0, 0, 0);         // dead current replaced
    send_fields(CMD_KILL, 0, 0, 0);
    send_fields(CMD_WAKE, 1, 0, 0);
    drain();
  endtask

  task automatic test_slice_extremes();
    write_slice(8'd1);
    repeat (20) send_fields(CMD_TICK, 0, 0, 0);
    write_slice(8'd255);
    repeat (10) send_fields(CMD_TICK, 0, 0, 0);
  endtask

  task automatic test_random(input int count, input logic [7:0] slice);
    write_slice(slice);
    repeat (count) send_cmd(random_cmd(1'b1));
  endtask

  task automatic test_table_full();
    drain();
    repeat (SLOTS + 1)
      send_fields(CMD_ADMIT, 0, $urandom_range(0, 255), 1'($urandom_range(0, 1)));
    repeat (200) send_cmd(random_cmd(1'b0));
    // kill everything off to reach the empty-ring cases
    repeat (SLOTS + 2) send_fields(CMD_KILL, 0, 0, 0);
    repeat (10) send_cmd(random_cmd(1'b1));
  endtask

  initial begin
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    for (int i = 0; i < SLOTS; i++) begin
      sched_state[i] = ST_DEAD;
      sched_prio[i] = '0;
      sched_user[i] = 1'b0;
      sched_ticks[i] = 8'd10;
    end
    sched_state[0] = ST_RUNNING;
    sched_ring = '0;
    sched_ring[0] = 1'b1;
    sched_used = 1;
    sched_run = 0;
    sched_slice = 8'd10;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basics();
    test_slice_extremes();
    test_random(400, 8'd1);
    test_random(400, 8'd3);
    test_random(350, 8'($urandom_range(2, 254)));
    test_random(300, 8'd255);
    test_table_full();
    drain();

    $display("ran %0d commands, %0d results checked, %0d task switches", n_sent, n_checked,
             n_switches);
    $display("table-full results %0d, no-task results %0d, time slices 1..255", n_full,
             n_empty);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/prrts_pkg.sv
sv/prrts_if.sv
sv/prrts_scan.sv
sv/priority_round_robin_task_scheduler_core.sv
sv/prrts_checker.sv
sim/tb_priority_round_robin_task_scheduler_core.sv
